>>> design/msfb_pkg.sv
package msfb_pkg;

    localparam int DATA_W    = 16;
    localparam int FRAC_W    = 11;
    localparam int ACC_W     = 40;
    localparam int SLOPE_W   = 22;
    localparam int LAY_W     = 2;
    localparam int IDX_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 5;
    localparam int WID_W     = 5;
    localparam int NUM_WIDTHS = 4;
    localparam int W_DEPTH   = 768;
    localparam int B_DEPTH   = 48;
    localparam int A_DEPTH   = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_3     = 3'd4;

    localparam logic KIND_ACT   = 1'b0;
    localparam logic KIND_DELTA = 1'b1;

    typedef enum logic [1:0] {
        MODE_WEIGHT = 2'd0,
        MODE_BIAS   = 2'd1,
        MODE_SAMPLE = 2'd2,
        MODE_TARGET = 2'd3
    } mode_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_F_BIAS_RD,
        S_F_BIAS,
        S_F_RD,
        S_F_MUL,
        S_F_ADD,
        S_F_SIG1,
        S_F_SIG2,
        S_E_RD,
        S_E_LOAD,
        S_E_EMIT,
        S_D_RD,
        S_D_LOAD,
        S_D_SL1,
        S_D_SL2,
        S_D_MUL,
        S_D_FIN,
        S_H_ZERO,
        S_H_RD,
        S_H_MUL,
        S_H_ADD,
        S_H_YRD,
        S_H_LOAD,
        S_H_SL1,
        S_H_SL2,
        S_H_MUL2,
        S_H_FIN
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACC_BIAS,
        OP_ACC_ZERO,
        OP_MUL_FWD,
        OP_MUL_BACK,
        OP_ADD,
        OP_SIG_MUL,
        OP_SIG_FIN,
        OP_LOAD_Y,
        OP_SLOPE_MUL,
        OP_SLOPE_FIN,
        OP_DOUT_MUL,
        OP_DHID_MUL,
        OP_DFIN,
        OP_EMIT_Y
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [LAY_W-1:0] lay;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [LAY_W-1:0] a_lay;
        logic [IDX_W-1:0] a_idx;
        logic [IDX_W-1:0] didx;
        logic             buf_sel;
        logic [LAY_W-1:0] out_layer;
        logic             final_flag;
    } dp_cmd_t;

endpackage

>>> design/msfb_ram.sv
module msfb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/msfb_ctrl.sv
module msfb_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [msfb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [msfb_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  logic                               in_accept,
    input  logic [1:0]                         in_mode,
    input  logic                               in_last,
    input  logic                               in_grad,
    input  logic                               out_busy,
    output msfb_pkg::dp_cmd_t                  cmd,
    output logic                               busy
);
    import msfb_pkg::*;

    state_t state_reg, state_next;
    logic [LAY_W-1:0] lc_reg;
    logic [WID_W-1:0] width_reg [NUM_WIDTHS];
    logic [LAY_W-1:0] l_reg, l_next;
    logic [IDX_W-1:0] r_reg, r_next;
    logic [IDX_W-1:0] c_reg, c_next;
    logic cur_reg, cur_next;
    logic grad_reg, grad_next;
    logic pending_reg, pending_next;
    logic [IDX_W-1:0] wm1 [NUM_WIDTHS];
    logic [LAY_W-1:0] nl, nl_m1, lp1, lp2;
    logic start_fwd, start_grad;

    always_comb
    begin
        for (int i = 0; i < NUM_WIDTHS; i++)
        begin
            if (width_reg[i] == '0)
                wm1[i] = '0;
            else if (width_reg[i] > WID_W'(16))
                wm1[i] = '1;
            else
                wm1[i] = IDX_W'(width_reg[i] - WID_W'(1));
        end
    end

    assign nl    = (lc_reg == '0) ? LAY_W'(1) : lc_reg;
    assign nl_m1 = nl - LAY_W'(1);
    assign lp1   = l_reg + LAY_W'(1);
    assign lp2   = l_reg + LAY_W'(2);

    assign start_fwd  = in_accept && (in_mode == MODE_SAMPLE) && in_last && !in_grad;
    assign start_grad = in_accept && (in_mode == MODE_TARGET) && in_last && pending_reg;
    assign busy       = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg       <= LAY_W'(2);
            width_reg[0] <= WID_W'(5);
            width_reg[1] <= WID_W'(3);
            width_reg[2] <= WID_W'(2);
            width_reg[3] <= WID_W'(1);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_LAYER_COUNT)
                lc_reg <= cfg_data[LAY_W-1:0];
            else if (cfg_index <= CFG_WIDTH_3)
                width_reg[2'(cfg_index - CFG_WIDTH_0)] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            l_reg       <= '0;
            r_reg       <= '0;
            c_reg       <= '0;
            cur_reg     <= 1'b0;
            grad_reg    <= 1'b0;
            pending_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            l_reg       <= l_next;
            r_reg       <= r_next;
            c_reg       <= c_next;
            cur_reg     <= cur_next;
            grad_reg    <= grad_next;
            pending_reg <= pending_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (start_fwd || start_grad) state_next = S_F_BIAS_RD;
            S_F_BIAS_RD: state_next = S_F_BIAS;
            S_F_BIAS:    state_next = S_F_RD;
            S_F_RD:      state_next = S_F_MUL;
            S_F_MUL:     state_next = S_F_ADD;
            S_F_ADD:     state_next = (c_reg == wm1[l_reg]) ? S_F_SIG1 : S_F_RD;
            S_F_SIG1:    state_next = S_F_SIG2;
            S_F_SIG2:
            begin
                if (r_reg == wm1[lp1] && l_reg == nl_m1)
                    state_next = S_E_RD;
                else
                    state_next = S_F_BIAS_RD;
            end
            S_E_RD:      state_next = S_E_LOAD;
            S_E_LOAD:    state_next = S_E_EMIT;
            S_E_EMIT:
            begin
                if (!out_busy)
                begin
                    if (r_reg != wm1[nl])
                        state_next = S_E_RD;
                    else
                        state_next = grad_reg ? S_D_RD : S_IDLE;
                end
            end
            S_D_RD:      state_next = S_D_LOAD;
            S_D_LOAD:    state_next = S_D_SL1;
            S_D_SL1:     state_next = S_D_SL2;
            S_D_SL2:     state_next = S_D_MUL;
            S_D_MUL:     state_next = S_D_FIN;
            S_D_FIN:
            begin
                if (!out_busy)
                begin
                    if (r_reg != wm1[nl])
                        state_next = S_D_RD;
                    else
                        state_next = (nl == LAY_W'(1)) ? S_IDLE : S_H_ZERO;
                end
            end
            S_H_ZERO:    state_next = S_H_RD;
            S_H_RD:      state_next = S_H_MUL;
            S_H_MUL:     state_next = S_H_ADD;
            S_H_ADD:     state_next = (c_reg == wm1[lp2]) ? S_H_YRD : S_H_RD;
            S_H_YRD:     state_next = S_H_LOAD;
            S_H_LOAD:    state_next = S_H_SL1;
            S_H_SL1:     state_next = S_H_SL2;
            S_H_SL2:     state_next = S_H_MUL2;
            S_H_MUL2:    state_next = S_H_FIN;
            S_H_FIN:
            begin
                if (!out_busy)
                begin
                    if (r_reg == wm1[lp1] && l_reg == '0)
                        state_next = S_IDLE;
                    else
                        state_next = S_H_ZERO;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        l_next       = l_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        cur_next     = cur_reg;
        grad_next    = grad_reg;
        pending_next = pending_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && in_mode == MODE_SAMPLE)
                    pending_next = in_grad;
                if (start_grad)
                    pending_next = 1'b0;
                if (start_fwd || start_grad)
                begin
                    l_next    = '0;
                    r_next    = '0;
                    c_next    = '0;
                    cur_next  = 1'b0;
                    grad_next = start_grad;
                end
            end
            S_F_BIAS, S_H_ZERO: c_next = '0;
            S_F_ADD:  if (c_reg != wm1[l_reg]) c_next = c_reg + IDX_W'(1);
            S_H_ADD:  if (c_reg != wm1[lp2]) c_next = c_reg + IDX_W'(1);
            S_F_SIG2:
            begin
                if (r_reg == wm1[lp1])
                begin
                    r_next = '0;
                    if (l_reg != nl_m1)
                        l_next = lp1;
                end
                else
                    r_next = r_reg + IDX_W'(1);
            end
            S_E_EMIT:
            begin
                if (!out_busy)
                    r_next = (r_reg == wm1[nl]) ? '0 : r_reg + IDX_W'(1);
            end
            S_D_FIN:
            begin
                if (!out_busy)
                begin
                    if (r_reg == wm1[nl])
                    begin
                        r_next   = '0;
                        l_next   = nl - LAY_W'(2);
                        cur_next = 1'b1;
                    end
                    else
                        r_next = r_reg + IDX_W'(1);
                end
            end
            S_H_FIN:
            begin
                if (!out_busy)
                begin
                    if (r_reg == wm1[lp1])
                    begin
                        r_next   = '0;
                        l_next   = l_reg - LAY_W'(1);
                        cur_next = !cur_reg;
                    end
                    else
                        r_next = r_reg + IDX_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.op = OP_NONE;
        cmd.buf_sel = cur_reg;
        unique case (state_reg)
            S_F_BIAS_RD:
            begin
                cmd.lay = l_reg;
                cmd.row = r_reg;
            end
            S_F_BIAS: cmd.op = OP_ACC_BIAS;
            S_F_RD:
            begin
                cmd.lay   = l_reg;
                cmd.row   = r_reg;
                cmd.col   = c_reg;
                cmd.a_lay = l_reg;
                cmd.a_idx = c_reg;
            end
            S_F_MUL:  cmd.op = OP_MUL_FWD;
            S_F_ADD, S_H_ADD: cmd.op = OP_ADD;
            S_F_SIG1: cmd.op = OP_SIG_MUL;
            S_F_SIG2:
            begin
                cmd.op    = OP_SIG_FIN;
                cmd.a_lay = lp1;
                cmd.a_idx = r_reg;
            end
            S_E_RD, S_D_RD:
            begin
                cmd.a_lay = nl;
                cmd.a_idx = r_reg;
            end
            S_E_LOAD, S_D_LOAD, S_H_LOAD: cmd.op = OP_LOAD_Y;
            S_E_EMIT:
            begin
                cmd.op         = out_busy ? OP_NONE : OP_EMIT_Y;
                cmd.a_idx      = r_reg;
                cmd.out_layer  = nl_m1;
                cmd.final_flag = !grad_reg && (r_reg == wm1[nl]);
            end
            S_D_SL1, S_H_SL1: cmd.op = OP_SLOPE_MUL;
            S_D_SL2, S_H_SL2: cmd.op = OP_SLOPE_FIN;
            S_D_MUL:
            begin
                cmd.op    = OP_DOUT_MUL;
                cmd.a_idx = r_reg;
            end
            S_D_FIN:
            begin
                cmd.op         = out_busy ? OP_NONE : OP_DFIN;
                cmd.a_idx      = r_reg;
                cmd.out_layer  = nl_m1;
                cmd.final_flag = (nl == LAY_W'(1)) && (r_reg == wm1[nl]);
            end
            S_H_ZERO: cmd.op = OP_ACC_ZERO;
            S_H_RD:
            begin
                cmd.lay = lp1;
                cmd.row = c_reg;
                cmd.col = r_reg;
            end
            S_H_MUL:
            begin
                cmd.op   = OP_MUL_BACK;
                cmd.didx = c_reg;
            end
            S_H_YRD:
            begin
                cmd.a_lay = lp1;
                cmd.a_idx = r_reg;
            end
            S_H_MUL2: cmd.op = OP_DHID_MUL;
            S_H_FIN:
            begin
                cmd.op         = out_busy ? OP_NONE : OP_DFIN;
                cmd.a_idx      = r_reg;
                cmd.out_layer  = l_reg;
                cmd.final_flag = (l_reg == '0) && (r_reg == wm1[lp1]);
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> design/msfb_datapath.sv
module msfb_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_accept,
    input  logic [1:0]                         in_mode,
    input  logic [1:0]                         in_layer,
    input  logic [3:0]                         in_row,
    input  logic [3:0]                         in_col,
    input  logic signed [msfb_pkg::DATA_W-1:0] in_value,
    input  msfb_pkg::dp_cmd_t                  cmd,
    output logic                               out_busy,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               kind,
    output logic [1:0]                         out_layer,
    output logic [3:0]                         out_index,
    output logic signed [msfb_pkg::DATA_W-1:0] out_value,
    output logic                               final_res
);
    import msfb_pkg::*;

    function automatic logic [11:0] knot_f(input logic [4:0] k);
        logic [11:0] v;
        unique case (k)
            5'd0:  v = 12'd1;
            5'd1:  v = 12'd2;
            5'd2:  v = 12'd5;
            5'd3:  v = 12'd14;
            5'd4:  v = 12'd37;
            5'd5:  v = 12'd97;
            5'd6:  v = 12'd244;
            5'd7:  v = 12'd551;
            5'd8:  v = 12'd1024;
            5'd9:  v = 12'd1497;
            5'd10: v = 12'd1804;
            5'd11: v = 12'd1951;
            5'd12: v = 12'd2011;
            5'd13: v = 12'd2034;
            5'd14: v = 12'd2043;
            5'd15: v = 12'd2046;
            5'd16: v = 12'd2047;
            default: v = 12'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [DATA_W-1:0] shift_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-FRAC_W-1:0] s;
        logic signed [DATA_W-1:0] r;
        s = v[ACC_W-1:FRAC_W];
        if (s > (ACC_W-FRAC_W)'(32767))
            r = 16'sh7FFF;
        else if (s < -(ACC_W-FRAC_W)'(32768))
            r = 16'sh8000;
        else
            r = s[DATA_W-1:0];
        return r;
    endfunction

    logic signed [ACC_W-1:0]   acc_reg, prod_reg;
    logic signed [DATA_W-1:0]  y_reg, base_reg;
    logic signed [SLOPE_W-1:0] s_reg;
    logic [DATA_W-1:0] w_rdata, b_rdata, a_rdata;
    logic [DATA_W-1:0] target_reg [16];
    logic [DATA_W-1:0] delta_reg [32];
    logic w_we, b_we, a_we;
    logic [5:0] a_waddr;
    logic [DATA_W-1:0] a_wdata;
    logic signed [DATA_W-1:0] z, back, d_val, sig_y, d_rd, t_rd;
    logic signed [16:0] zx, y_sx, one_my, dy;
    logic [11:0] ka, kb;
    logic [4:0] seg;

    assign w_we = in_accept && in_mode == MODE_WEIGHT && in_layer != 2'd3;
    assign b_we = in_accept && in_mode == MODE_BIAS && in_layer != 2'd3;
    assign a_we = (in_accept && in_mode == MODE_SAMPLE) || cmd.op == OP_SIG_FIN;
    assign a_waddr = (cmd.op == OP_SIG_FIN) ? {cmd.a_lay, cmd.a_idx} : {2'd0, in_row};
    assign a_wdata = (cmd.op == OP_SIG_FIN) ? sig_y : in_value;

    msfb_ram #(.WIDTH(DATA_W), .DEPTH(W_DEPTH)) u_wram (
        .clk(clk), .we(w_we), .waddr({in_layer, in_row, in_col}), .wdata(in_value),
        .raddr({cmd.lay, cmd.row, cmd.col}), .rdata(w_rdata)
    );
    msfb_ram #(.WIDTH(DATA_W), .DEPTH(B_DEPTH)) u_bram (
        .clk(clk), .we(b_we), .waddr({in_layer, in_row}), .wdata(in_value),
        .raddr({cmd.lay, cmd.row}), .rdata(b_rdata)
    );
    msfb_ram #(.WIDTH(DATA_W), .DEPTH(A_DEPTH)) u_aram (
        .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .raddr({cmd.a_lay, cmd.a_idx}), .rdata(a_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (in_accept && in_mode == MODE_TARGET)
            target_reg[in_row] <= in_value;
        if (cmd.op == OP_DFIN)
            delta_reg[{cmd.buf_sel, cmd.a_idx}] <= d_val;
    end

    assign z      = shift_sat(acc_reg);
    assign back   = z;
    assign zx     = 17'(z) + 17'sd16384;
    assign seg    = {1'b0, zx[14:11]};
    assign ka     = knot_f(seg);
    assign kb     = knot_f(seg + 5'd1);
    assign sig_y  = base_reg + DATA_W'(prod_reg[ACC_W-1:FRAC_W]);
    assign y_sx   = 17'(y_reg);
    assign one_my = 17'sd2048 - y_sx;
    assign t_rd   = target_reg[cmd.a_idx];
    assign dy     = y_sx - 17'(t_rd);
    assign d_rd   = delta_reg[{!cmd.buf_sel, cmd.didx}];
    assign d_val  = shift_sat(prod_reg);

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_ACC_BIAS:  acc_reg <= ACC_W'(signed'(b_rdata)) <<< FRAC_W;
            OP_ACC_ZERO:  acc_reg <= '0;
            OP_MUL_FWD:   prod_reg <= ACC_W'(signed'(w_rdata) * signed'(a_rdata));
            OP_MUL_BACK:  prod_reg <= ACC_W'(signed'(w_rdata) * d_rd);
            OP_ADD:       acc_reg <= acc_reg + prod_reg;
            OP_SIG_MUL:
            begin
                if (zx[16])
                begin
                    base_reg <= DATA_W'(knot_f(5'd0));
                    prod_reg <= '0;
                end
                else if (zx[15])
                begin
                    base_reg <= DATA_W'(knot_f(5'd16));
                    prod_reg <= '0;
                end
                else
                begin
                    base_reg <= DATA_W'(ka);
                    prod_reg <= ACC_W'((kb - ka) * zx[10:0]);
                end
            end
            OP_LOAD_Y:    y_reg <= a_rdata;
            OP_SLOPE_MUL: prod_reg <= ACC_W'(y_sx * one_my);
            OP_SLOPE_FIN: s_reg <= prod_reg[SLOPE_W+FRAC_W-1:FRAC_W];
            OP_DOUT_MUL:  prod_reg <= ACC_W'(dy * s_reg);
            OP_DHID_MUL:  prod_reg <= ACC_W'(back * s_reg);
            default:
            begin
            end
        endcase
    end

    assign out_busy = out_valid && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.op == OP_EMIT_Y || cmd.op == OP_DFIN)
            out_valid <= 1'b1;
        else if (!out_stall)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_EMIT_Y || cmd.op == OP_DFIN)
        begin
            kind      <= (cmd.op == OP_DFIN) ? KIND_DELTA : KIND_ACT;
            out_layer <= cmd.out_layer;
            out_index <= cmd.a_idx;
            out_value <= (cmd.op == OP_DFIN) ? d_val : y_reg;
            final_res <= cmd.final_flag;
        end
    end

endmodule

>>> design/mlp_sigmoid_forward_backprop_unit.sv
// Fully connected sigmoid network with optional backpropagation of layer deltas.
// Input requests carry weight words, bias words, sample elements and target
// elements; each is taken when in_valid is high and in_stall is low. Loads are
// accepted one per cycle while no run is in progress. The last sample element
// (without gradient) or the last target element (after a sample with gradient)
// starts a run, and in_stall stays high until the run ends.
// A run walks every neuron with one shared multiply-accumulate unit: the forward
// pass first, then the emitted output activations and, for a run with gradient,
// the output deltas followed by the hidden deltas.
// Results leave through an output register as out_valid requests; final_res
// marks the last one of a run. A stalled result holds and the run pauses at
// its next result until the register drains; once the last result of a run
// sits in the register, the run has ended and requests are taken again.
// The configuration channel is always ready; the user must write it only while idle,
// which the block does not enforce. Reset clears the control state and restores the
// register defaults; the weight, bias, activation and target stores hold nothing until written.
module mlp_sigmoid_forward_backprop_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [msfb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [msfb_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         mode,
    input  logic [1:0]                         layer,
    input  logic [3:0]                         row,
    input  logic [3:0]                         col,
    input  logic signed [15:0]                 value,
    input  logic                               want_gradient,
    input  logic                               last,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               kind,
    output logic [1:0]                         out_layer,
    output logic [3:0]                         out_index,
    output logic signed [15:0]                 out_value,
    output logic                               final_res
);
    import msfb_pkg::*;

    dp_cmd_t cmd;
    logic in_accept, out_busy, busy;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy;
    assign in_accept = in_valid && !busy;

    msfb_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_accept(in_accept), .in_mode(mode), .in_last(last), .in_grad(want_gradient),
        .out_busy(out_busy), .cmd(cmd), .busy(busy)
    );

    msfb_datapath u_dp (
        .clk(clk), .rst_n(rst_n),
        .in_accept(in_accept), .in_mode(mode), .in_layer(layer), .in_row(row),
        .in_col(col), .in_value(value), .cmd(cmd), .out_busy(out_busy),
        .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
        .out_layer(out_layer), .out_index(out_index), .out_value(out_value),
        .final_res(final_res)
    );

endmodule

>>> design/msfb_checker.sv
module msfb_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic [1:0]                     mode,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic                           kind,
    input logic signed [15:0]             out_value
);
    import msfb_pkg::*;

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_value);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("stalled result changed");

    property p_load_no_stall;
        @(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (mode == MODE_WEIGHT || mode == MODE_BIAS) |=> !in_stall;
    endproperty
    a_load_no_stall: assert property (p_load_no_stall) else $error("load started a run");

    property p_act_range;
        @(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ACT |-> out_value != 16'sd0 && out_value[15:11] == 5'd0;
    endproperty
    a_act_range: assert property (p_act_range) else $error("activation out of sigmoid range");

endmodule

bind mlp_sigmoid_forward_backprop_unit msfb_checker u_msfb_checker (.*);
